### sv/hlh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlh_pkg
// Shared constants and helpers for the HSL lightness histogram.
// ----------------------------------------------------------------------------
package hlh_pkg;

    localparam int BINS        = 1024;
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_W       = $clog2(BINS);
    localparam int N_W         = $clog2(BINS + 1);
    localparam int CFG_W       = 11;
    localparam int LIGHT_W     = 8;
    localparam int OUT_W       = 32;
    localparam int BIN_COUNT_RESET = 20;

    // Scaled bin position is n * L, divided by 255 through a reciprocal multiply.
    localparam int PROD_W    = N_W + LIGHT_W;
    localparam int DIV_SHIFT = PROD_W + 8;
    localparam int DIV_MW    = DIV_SHIFT - 7;
    localparam logic [DIV_MW-1:0] DIV_MULT =
        DIV_MW'(((64'd1 << DIV_SHIFT) + 64'd254) / 64'd255);
    localparam int QUOT_W = PROD_W + DIV_MW - DIV_SHIFT;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic {
        CMD_ACCUM = 1'b0,
        CMD_READ  = 1'b1
    } t_cmd;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
    endfunction

endpackage

### sv/hsl_lightness_histogram_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_lightness_histogram_top
// Lightness histogram of RGB pixels with read-and-clear bin readout.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the bin memory with busy
// high. A pixel word occupies the block from acceptance through the scale
// multiply, reciprocal divide, memory read, write back and the return to
// idle, and a read word through the memory read, write back and the return
// to idle; the state machine takes one word at a time through the
// read-modify-write of the bin memory. A read result appears on the output
// ports with o_strobe for exactly one cycle and must be taken then; the
// receiver cannot stall. Configuration writes are always ready.
// ----------------------------------------------------------------------------
module hsl_lightness_histogram_top
    import hlh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_command,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    input  logic [9:0]          i_read_bin,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output logic                o_strobe,
    output logic [9:0]          o_bin_number,
    output logic [OUT_W-1:0]    o_bin_total,
    output logic [OUT_W-1:0]    o_pixel_total
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_DIV,
        S_READ,
        S_WRITE
    } t_state;

    t_state                   r_state;
    logic [BIN_W-1:0]         r_clr_addr;
    logic [CFG_W-1:0]         r_bin_count;
    logic [COUNT_WIDTH-1:0]   r_pixels;
    t_cmd                     r_cmd;
    logic [LIGHT_W-1:0]       r_light;
    logic [PROD_W-1:0]        r_prod;
    logic [BIN_W-1:0]         r_addr;
    logic                     r_hit;
    logic                     r_strobe;
    logic [9:0]               r_bin_number;
    logic [OUT_W-1:0]         r_bin_total;
    logic [OUT_W-1:0]         r_pixel_total;

    logic [N_W-1:0]           n_bins;
    logic [7:0]               px_max;
    logic [7:0]               px_min;
    logic [LIGHT_W-1:0]       light;
    logic [PROD_W+DIV_MW-1:0] quot_full;
    logic [QUOT_W-1:0]        quot;
    logic [N_W-1:0]           bin_idx;
    logic                     last_bin;
    logic                     ram_we;
    logic [BIN_W-1:0]         ram_waddr;
    logic [COUNT_WIDTH-1:0]   ram_wdata;
    logic [COUNT_WIDTH-1:0]   ram_rdata;

    always_comb begin
        if (r_bin_count == '0) begin
            n_bins = N_W'(1);
        end else if (r_bin_count > CFG_W'(BINS)) begin
            n_bins = N_W'(BINS);
        end else begin
            n_bins = N_W'(r_bin_count);
        end
    end

    always_comb begin
        px_max = (i_red > i_green) ? i_red : i_green;
        px_max = (px_max > i_blue) ? px_max : i_blue;
        px_min = (i_red < i_green) ? i_red : i_green;
        px_min = (px_min < i_blue) ? px_min : i_blue;
        light  = LIGHT_W'(({1'b0, px_max} + {1'b0, px_min}) >> 1);
    end

    always_comb begin
        quot_full = PROD_W'(r_prod) * (PROD_W + DIV_MW)'(DIV_MULT);
        quot      = quot_full[PROD_W+DIV_MW-1:DIV_SHIFT];
        if (quot >= QUOT_W'(n_bins)) begin
            bin_idx = n_bins - N_W'(1);
        end else begin
            bin_idx = N_W'(quot);
        end
    end

    assign last_bin = (N_W'(r_addr) == (n_bins - N_W'(1)));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
        end else if (r_state == S_WRITE) begin
            if (r_cmd == CMD_ACCUM) begin
                ram_we    = 1'b1;
                ram_wdata = sat_inc(ram_rdata);
            end else begin
                ram_we = r_hit;
            end
        end
    end

    hlh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (BINS)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_bin_count <= CFG_W'(BIN_COUNT_RESET);
            r_pixels    <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid) begin
                r_bin_count <= i_cfg_data;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + BIN_W'(1);
                    if (r_clr_addr == BIN_W'(BINS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= t_cmd'(i_command);
                        r_light <= light;
                        r_addr  <= BIN_W'(i_read_bin);
                        r_hit   <= (N_W'(i_read_bin) < n_bins);
                        r_state <= (t_cmd'(i_command) == CMD_READ) ? S_READ : S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(n_bins) * PROD_W'(r_light);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_addr  <= BIN_W'(bin_idx);
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (r_cmd == CMD_ACCUM) begin
                        r_pixels <= sat_inc(r_pixels);
                    end else begin
                        r_strobe      <= 1'b1;
                        r_bin_number  <= 10'(r_addr);
                        r_bin_total   <= r_hit ? OUT_W'(ram_rdata) : '0;
                        r_pixel_total <= OUT_W'(r_pixels);
                        if (r_hit && last_bin) begin
                            r_pixels <= '0;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_strobe      = r_strobe;
    assign o_bin_number  = r_bin_number;
    assign o_bin_total   = r_bin_total;
    assign o_pixel_total = r_pixel_total;

endmodule

### sv/hlh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlh_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module hlh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
